// ===== rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared widths, command codes and direction marks of the LCS block.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int FUNC_W = 2;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 6;

  localparam int DEF_MAX_LEN    = 32;
  localparam int DEF_ELEM_WIDTH = 32;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN         = 2'd2;

  typedef enum logic [1:0] {
    MARK_DIAG = 2'd1,
    MARK_UP   = 2'd2,
    MARK_LEFT = 2'd3
  } mark_t;

endpackage

// ===== rtl/lcs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_in_if
// Command channel: load an element into either sequence or start a run.
// ----------------------------------------------------------------------------
interface lcs_in_if;
  logic                              valid;
  logic                              ready;
  logic        [lcs_pkg::FUNC_W-1:0] func;
  logic signed [lcs_pkg::VAL_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== rtl/lcs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_out_if
// Result channel: one common subsequence element per request.
// ----------------------------------------------------------------------------
interface lcs_out_if;
  logic                             valid;
  logic                             ready;
  logic        [lcs_pkg::LEN_W-1:0] lcs_length;
  logic signed [lcs_pkg::VAL_W-1:0] element;
  logic                             element_valid;
  logic                             overflow;
  logic                             last;

  modport source (output valid, output lcs_length, output element,
                  output element_valid, output overflow, output last, input ready);
  modport sink   (input valid, input lcs_length, input element,
                  input element_valid, input overflow, input last, output ready);
endinterface

// ===== rtl/lcs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lcs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_cell
// Shared cell unit: element compare, diagonal increment and up/left maximum.
// ----------------------------------------------------------------------------
module lcs_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int SCORE_W    = 6
) (
  input  logic [ELEM_WIDTH-1:0] a,
  input  logic [ELEM_WIDTH-1:0] b,
  input  logic [SCORE_W-1:0]    up,
  input  logic [SCORE_W-1:0]    diag,
  input  logic [SCORE_W-1:0]    left,
  output logic [SCORE_W-1:0]    score,
  output lcs_pkg::mark_t        mark
);

  always_comb begin
    if (a == b) begin
      score = diag + 1'b1;
      mark  = lcs_pkg::MARK_DIAG;
    end else if (up >= left) begin
      score = up;
      mark  = lcs_pkg::MARK_UP;
    end else begin
      score = left;
      mark  = lcs_pkg::MARK_LEFT;
    end
  end

endmodule

// ===== rtl/lcs_length_traceback.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_traceback
// Longest common subsequence of two loaded sequences, with traceback.
//
// cmd channel: func 0 appends value to the first sequence, func 1 to the
// second, func 2 runs. A load into a full sequence is dropped and sets
// the overflow flag. Code 3 is ignored.
// res channel: a run returns the subsequence in forward order, one request
// per element, each carrying the length and the overflow flag, last on the
// final one. An empty result gives one request with element_valid low.
// A run of m by n elements fills the table with one cell unit shared by
// all cells, each cell waiting on its RAM reads, then traces back through
// the direction RAM and reads each result from the trace RAM. cmd is not
// ready during a run; a stalled result is held in the output register
// until taken. Both counts and the overflow flag clear after the last
// result. Reset returns the block to idle with empty sequences; no RAM is
// cleared.
// ----------------------------------------------------------------------------
module lcs_length_traceback #(
  parameter int MAX_LEN    = lcs_pkg::DEF_MAX_LEN,
  parameter int ELEM_WIDTH = lcs_pkg::DEF_ELEM_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  lcs_in_if.sink    cmd,
  lcs_out_if.source res
);

  localparam int IW        = $clog2(MAX_LEN + 1);
  localparam int SW        = IW;
  localparam int AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DD        = MAX_LEN * MAX_LEN;
  localparam int DAW       = (DD > 1) ? $clog2(DD) : 1;
  localparam int OUT_LEN_W = lcs_pkg::LEN_W;
  localparam int OUT_VAL_W = lcs_pkg::VAL_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW_RD,
    S_ROW_LD,
    S_CELL_RD,
    S_CELL_WR,
    S_TB_RD,
    S_TB_ACT,
    S_EM_START,
    S_EM_RD,
    S_EM_SHOW,
    S_EM_WAIT
  } state_t;

  state_t state;

  logic [IW-1:0]         first_count;
  logic [IW-1:0]         second_count;
  logic                  overflow_flag;
  logic [IW-1:0]         i;
  logic [IW-1:0]         j;
  logic [IW-1:0]         k;
  logic [DAW-1:0]        base;
  logic [SW-1:0]         diag;
  logic [SW-1:0]         left;
  logic [SW-1:0]         len;
  logic [AW-1:0]         idx;
  logic [ELEM_WIDTH-1:0] a_elem;

  logic                  out_valid;
  logic [OUT_LEN_W-1:0]  out_length;
  logic [OUT_VAL_W-1:0]  out_element;
  logic                  out_element_valid;
  logic                  out_overflow;
  logic                  out_last;

  logic                  accept;
  logic                  load_first;
  logic                  load_second;
  logic [IW-1:0]         i_m1;
  logic [IW-1:0]         j_m1;
  logic [IW-1:0]         k_m1;
  logic [DAW-1:0]        dir_addr;
  logic [ELEM_WIDTH-1:0] load_data;

  logic [ELEM_WIDTH-1:0] first_rdata;
  logic [ELEM_WIDTH-1:0] second_rdata;
  logic [SW-1:0]         row_rdata;
  logic [1:0]            dir_rdata;
  logic [ELEM_WIDTH-1:0] trace_rdata;

  logic [SW-1:0]         up;
  logic [SW-1:0]         cell_score;
  lcs_pkg::mark_t        cell_mark;
  lcs_pkg::mark_t        tb_mark;
  logic                  tb_up;
  logic                  tb_left;
  logic                  tb_done;
  logic                  fill_write;
  logic                  trace_write;

  assign accept      = cmd.valid && cmd.ready;
  assign load_first  = accept && (cmd.func == lcs_pkg::FUNC_LOAD_FIRST)
                       && (first_count < IW'(MAX_LEN));
  assign load_second = accept && (cmd.func == lcs_pkg::FUNC_LOAD_SECOND)
                       && (second_count < IW'(MAX_LEN));
  assign load_data   = ELEM_WIDTH'($unsigned(cmd.value));

  assign i_m1     = i - 1'b1;
  assign j_m1     = j - 1'b1;
  assign k_m1     = k - 1'b1;
  assign dir_addr = base + DAW'(j_m1);

  assign up          = (i == IW'(1)) ? '0 : row_rdata;
  assign fill_write  = (state == S_CELL_WR);
  assign tb_mark     = lcs_pkg::mark_t'(dir_rdata);
  assign tb_up       = (tb_mark == lcs_pkg::MARK_DIAG) || (tb_mark == lcs_pkg::MARK_UP);
  assign tb_left     = (tb_mark != lcs_pkg::MARK_UP);
  assign tb_done     = (tb_up && (i == IW'(1))) || (tb_left && (j == IW'(1)));
  assign trace_write = (state == S_TB_ACT) && (tb_mark == lcs_pkg::MARK_DIAG);

  assign cmd.ready         = (state == S_IDLE);
  assign res.valid         = out_valid;
  assign res.lcs_length    = out_length;
  assign res.element       = out_element;
  assign res.element_valid = out_element_valid;
  assign res.overflow      = out_overflow;
  assign res.last          = out_last;

  lcs_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_LEN)) u_first_ram (
    .clk   (clk),
    .we    (load_first),
    .waddr (first_count[AW-1:0]),
    .wdata (load_data),
    .raddr (i_m1[AW-1:0]),
    .rdata (first_rdata)
  );

  lcs_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_LEN)) u_second_ram (
    .clk   (clk),
    .we    (load_second),
    .waddr (second_count[AW-1:0]),
    .wdata (load_data),
    .raddr (j_m1[AW-1:0]),
    .rdata (second_rdata)
  );

  lcs_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_row_ram (
    .clk   (clk),
    .we    (fill_write),
    .waddr (j_m1[AW-1:0]),
    .wdata (cell_score),
    .raddr (j_m1[AW-1:0]),
    .rdata (row_rdata)
  );

  lcs_ram #(.WIDTH(2), .DEPTH(DD)) u_dir_ram (
    .clk   (clk),
    .we    (fill_write),
    .waddr (dir_addr),
    .wdata (cell_mark),
    .raddr (dir_addr),
    .rdata (dir_rdata)
  );

  lcs_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_LEN)) u_trace_ram (
    .clk   (clk),
    .we    (trace_write),
    .waddr (k[AW-1:0]),
    .wdata (first_rdata),
    .raddr (idx),
    .rdata (trace_rdata)
  );

  lcs_cell #(.ELEM_WIDTH(ELEM_WIDTH), .SCORE_W(SW)) u_cell (
    .a     (a_elem),
    .b     (second_rdata),
    .up    (up),
    .diag  (diag),
    .left  (left),
    .score (cell_score),
    .mark  (cell_mark)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.func)
              lcs_pkg::FUNC_LOAD_FIRST: begin
                if (load_first) begin
                  first_count <= first_count + 1'b1;
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              lcs_pkg::FUNC_LOAD_SECOND: begin
                if (load_second) begin
                  second_count <= second_count + 1'b1;
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              lcs_pkg::FUNC_RUN: begin
                i    <= IW'(1);
                base <= '0;
                len  <= '0;
                k    <= '0;
                if ((first_count == '0) || (second_count == '0)) begin
                  state <= S_EM_START;
                end else begin
                  state <= S_ROW_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ROW_RD: begin
          j     <= IW'(1);
          diag  <= '0;
          left  <= '0;
          state <= S_ROW_LD;
        end
        S_ROW_LD: begin
          a_elem <= first_rdata;
          state  <= S_CELL_RD;
        end
        S_CELL_RD: begin
          state <= S_CELL_WR;
        end
        S_CELL_WR: begin
          diag <= up;
          left <= cell_score;
          len  <= cell_score;
          if (j == second_count) begin
            if (i == first_count) begin
              state <= S_TB_RD;
            end else begin
              i     <= i + 1'b1;
              base  <= base + DAW'(MAX_LEN);
              state <= S_ROW_RD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_CELL_RD;
          end
        end
        S_TB_RD: begin
          state <= S_TB_ACT;
        end
        S_TB_ACT: begin
          if (tb_mark == lcs_pkg::MARK_DIAG) begin
            k <= k + 1'b1;
          end
          if (tb_up) begin
            i    <= i_m1;
            base <= base - DAW'(MAX_LEN);
          end
          if (tb_left) begin
            j <= j_m1;
          end
          state <= tb_done ? S_EM_START : S_TB_RD;
        end
        S_EM_START: begin
          if (k == '0) begin
            out_length        <= '0;
            out_element       <= '0;
            out_element_valid <= 1'b0;
            out_overflow      <= overflow_flag;
            out_last          <= 1'b1;
            out_valid         <= 1'b1;
            state             <= S_EM_WAIT;
          end else begin
            idx   <= k_m1[AW-1:0];
            state <= S_EM_RD;
          end
        end
        S_EM_RD: begin
          state <= S_EM_SHOW;
        end
        S_EM_SHOW: begin
          out_length        <= OUT_LEN_W'(len);
          out_element       <= OUT_VAL_W'(trace_rdata);
          out_element_valid <= 1'b1;
          out_overflow      <= overflow_flag;
          out_last          <= (idx == '0);
          out_valid         <= 1'b1;
          state             <= S_EM_WAIT;
        end
        S_EM_WAIT: begin
          if (res.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              first_count   <= '0;
              second_count  <= '0;
              overflow_flag <= 1'b0;
              state         <= S_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_EM_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/lcs_length_traceback_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_traceback_test
// Loads pairs of sequences through the cmd channel, runs the block and
// checks every emitted subsequence element against a local table-fill and
// traceback predictor. Directed cases cover empty sequences, extreme values,
// the up/left tie, no match and the ignored code; random runs use small
// alphabets to force matches, with a few full-size and overflowing loads,
// under changing sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
module lcs_length_traceback_test;
  import lcs_pkg::*;

  localparam int SEQ_DEPTH = DEF_MAX_LEN;
  localparam int QUIET_LIMIT = 20000;
  localparam int TARGET_REQUESTS = 330;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [LEN_W-1:0] len;
    logic [VAL_W-1:0] elem;
    logic             present;
    logic             ovf;
    logic             last;
  } lcs_result_t;

  class subseq_tracker;
    logic [VAL_W-1:0] seq_a[$];
    logic [VAL_W-1:0] seq_b[$];
    logic             ovf_seen;
    lcs_result_t      expected_elems[$];
    int               mismatches;

    function new();
      ovf_seen = 1'b0;
      mismatches = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    function void solve_lcs();
      int               m, n, i, j;
      int unsigned      score[0:SEQ_DEPTH][0:SEQ_DEPTH];
      mark_t            dir[1:SEQ_DEPTH][1:SEQ_DEPTH];
      logic [VAL_W-1:0] trail[$];
      lcs_result_t      r;
      m = seq_a.size();
      n = seq_b.size();
      for (i = 0; i <= m; i++) score[i][0] = 0;
      for (j = 0; j <= n; j++) score[0][j] = 0;
      for (i = 1; i <= m; i++) begin
        for (j = 1; j <= n; j++) begin
          if (seq_a[i-1] == seq_b[j-1]) begin
            score[i][j] = score[i-1][j-1] + 1;
            dir[i][j] = MARK_DIAG;
          end else if (score[i-1][j] >= score[i][j-1]) begin
            score[i][j] = score[i-1][j];
            dir[i][j] = MARK_UP;
          end else begin
            score[i][j] = score[i][j-1];
            dir[i][j] = MARK_LEFT;
          end
        end
      end
      i = m;
      j = n;
      while (i != 0 && j != 0) begin
        if (dir[i][j] == MARK_DIAG) begin
          trail.push_front(seq_a[i-1]);
          i--;
          j--;
        end else if (dir[i][j] == MARK_UP) begin
          i--;
        end else begin
          j--;
        end
      end
      if (trail.size() == 0) begin
        r.len = '0;
        r.elem = '0;
        r.present = 1'b0;
        r.ovf = ovf_seen;
        r.last = 1'b1;
        expected_elems.push_back(r);
      end else begin
        foreach (trail[k]) begin
          r.len = LEN_W'(score[m][n]);
          r.elem = trail[k];
          r.present = 1'b1;
          r.ovf = ovf_seen;
          r.last = (k == trail.size() - 1);
          expected_elems.push_back(r);
        end
      end
      seq_a.delete();
      seq_b.delete();
      ovf_seen = 1'b0;
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [VAL_W-1:0] v);
      case (f)
        FUNC_LOAD_FIRST: begin
          if (seq_a.size() < SEQ_DEPTH) seq_a.push_back(v);
          else ovf_seen = 1'b1;
        end
        FUNC_LOAD_SECOND: begin
          if (seq_b.size() < SEQ_DEPTH) seq_b.push_back(v);
          else ovf_seen = 1'b1;
        end
        FUNC_RUN: solve_lcs();
        default: ;
      endcase
    endfunction

    task check_result(logic [LEN_W-1:0] len, logic [VAL_W-1:0] elem, logic present,
                      logic ovf, logic last);
      lcs_result_t e;
      if (expected_elems.size() == 0) begin
        report($sformatf("unexpected result len=%0d elem=%h", len, elem));
      end else begin
        e = expected_elems.pop_front();
        if (len !== e.len)
          report($sformatf("lcs_length %0d, want %0d", len, e.len));
        if (elem !== e.elem)
          report($sformatf("element %h, want %h", elem, e.elem));
        if (present !== e.present)
          report($sformatf("element_valid %b, want %b", present, e.present));
        if (ovf !== e.ovf)
          report($sformatf("overflow %b, want %b", ovf, e.ovf));
        if (last !== e.last)
          report($sformatf("last %b, want %b", last, e.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  lcs_in_if  cmd();
  lcs_out_if res();

  lcs_length_traceback DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  subseq_tracker sb = new();

  int idle_pct;
  int stall_pct;
  int requests_sent;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result(res.lcs_length, res.element, res.element_valid, res.overflow,
                      res.last);
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(logic [FUNC_W-1:0] f, logic [VAL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.func <= f;
    cmd.value <= v;
    do @(posedge clk); while (!cmd.ready);
    sb.note_request(f, v);
    if (f != FUNC_UNUSED) requests_sent++;
  endtask

  task automatic load_and_run(int len_a, int len_b, int alphabet);
    int               ia, ib;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] v;
    ia = 0;
    ib = 0;
    base = $urandom();
    while (ia < len_a || ib < len_b) begin
      if ($urandom_range(99) < 4) push_request(FUNC_UNUSED, $urandom());
      v = (alphabet == 0) ? $urandom() : base + $urandom_range(alphabet - 1);
      if (ib >= len_b || (ia < len_a && $urandom_range(1) == 1)) begin
        push_request(FUNC_LOAD_FIRST, v);
        ia++;
      end else begin
        push_request(FUNC_LOAD_SECOND, v);
        ib++;
      end
    end
    push_request(FUNC_RUN, $urandom());
  endtask

  initial begin
    int run_no;
    int len_a, len_b;
    rst <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.func <= FUNC_LOAD_FIRST;
    cmd.value <= '0;
    idle_pct = 0;
    stall_pct = 0;
    requests_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // both sequences empty, then an ignored code
    push_request(FUNC_RUN, 32'h0);
    push_request(FUNC_UNUSED, 32'hFFFF_FFFF);
    // extreme values
    push_request(FUNC_LOAD_FIRST, 32'h8000_0000);
    push_request(FUNC_LOAD_FIRST, 32'h7FFF_FFFF);
    push_request(FUNC_LOAD_FIRST, 32'h0000_0000);
    push_request(FUNC_LOAD_FIRST, 32'hFFFF_FFFF);
    push_request(FUNC_LOAD_SECOND, 32'hFFFF_FFFF);
    push_request(FUNC_LOAD_SECOND, 32'h8000_0000);
    push_request(FUNC_LOAD_SECOND, 32'h7FFF_FFFF);
    push_request(FUNC_RUN, 32'h5555_5555);
    // first sequence empty
    push_request(FUNC_LOAD_SECOND, 32'd5);
    push_request(FUNC_RUN, 32'h0);
    // up/left tie
    push_request(FUNC_LOAD_FIRST, 32'd1);
    push_request(FUNC_LOAD_FIRST, 32'd2);
    push_request(FUNC_LOAD_SECOND, 32'd2);
    push_request(FUNC_LOAD_SECOND, 32'd1);
    push_request(FUNC_RUN, 32'hAAAA_AAAA);
    // no match
    push_request(FUNC_LOAD_FIRST, 32'd3);
    push_request(FUNC_LOAD_SECOND, 32'd4);
    push_request(FUNC_RUN, 32'h0);

    run_no = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      case ((run_no / 2) % 5)
        1: begin idle_pct = 77; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 77; end
        3: begin idle_pct = 21; stall_pct = 21; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (run_no == 0) begin
        load_and_run(SEQ_DEPTH + 1, SEQ_DEPTH, 1);
      end else if ($urandom_range(9) == 0) begin
        len_a = $urandom_range(SEQ_DEPTH + 2, SEQ_DEPTH - 4);
        len_b = $urandom_range(SEQ_DEPTH + 2, SEQ_DEPTH - 4);
        load_and_run(len_a, len_b, $urandom_range(5, 1));
      end else begin
        len_a = $urandom_range(8);
        len_b = $urandom_range(8);
        load_and_run(len_a, len_b, $urandom_range(5));
      end
      run_no++;
    end
    cmd.valid <= 1'b0;

    while (sb.expected_elems.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== lcs_length_traceback.f =====
rtl/lcs_pkg.sv
rtl/lcs_in_if.sv
rtl/lcs_out_if.sv
rtl/lcs_ram.sv
rtl/lcs_cell.sv
rtl/lcs_length_traceback.sv
verif/lcs_length_traceback_test.sv
